FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the heaviest-edge chain ordering block.
// Needs nothing else; simulation builds get the checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GHE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define GHE_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define GHE_ASSERT(lbl, clk, rstn, prop)
`define GHE_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

FILE: hw/rtl/ghe_pkg.sv
// Package for the heaviest-edge chain ordering block: widths, register indexes,
// sequencer states and the structs between the sequencer and the compare unit.
`default_nettype none
package ghe_pkg;
  localparam int NODE_W        = 6;
  localparam int WEIGHT_W      = 32;
  localparam int COUNT_W       = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;
  localparam int MASK_W        = 64;
  localparam int NODE_LIMIT    = 64;
  localparam int MIN_NODES     = 2;
  localparam int DEF_MAX_NODES = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_NODE  = 2'd2;

  typedef enum logic [8:0] {
    ST_CLR  = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_SEL  = 9'b000000100,
    ST_PAIR = 9'b000001000,
    ST_NBR  = 9'b000010000,
    ST_WAIT = 9'b000100000,
    ST_DEC  = 9'b001000000,
    ST_ASC  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              vld;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } cmp_cmd_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] ba;
    logic [NODE_W-1:0] bb;
  } cmp_res_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ghe_if.sv
// Valid/ready channel interfaces for input and result words of the ordering block.
// Depends on ghe_pkg for field widths.
`default_nettype none
interface ghe_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ghe_pkg::NODE_W-1:0]    from_node;
  logic [ghe_pkg::NODE_W-1:0]    to_node;
  logic [ghe_pkg::WEIGHT_W-1:0]  edge_weight;
  modport source (output valid, mode, from_node, to_node, edge_weight, input ready);
  modport sink (input valid, mode, from_node, to_node, edge_weight, output ready);
endinterface

interface ghe_out_if;
  logic                       valid;
  logic                       ready;
  logic [ghe_pkg::NODE_W-1:0] node;
  logic                       last;
  logic                       empty_res;
  modport source (output valid, node, last, empty_res, input ready);
  modport sink (input valid, node, last, empty_res, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ghe_wmem.sv
// Weight store: MAX_NODES x MAX_NODES words, one write and one registered read port.
// Depends on ghe_pkg for the weight width.
`default_nettype none
module ghe_wmem #(
  parameter int MAX_NODES = ghe_pkg::DEF_MAX_NODES
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(MAX_NODES*MAX_NODES)-1:0] waddr,
  input  wire logic [ghe_pkg::WEIGHT_W-1:0] wdata,
  input  wire logic [$clog2(MAX_NODES*MAX_NODES)-1:0] raddr,
  output logic      [ghe_pkg::WEIGHT_W-1:0] rdata_r
);
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  logic [ghe_pkg::WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ghe_cmp.sv
// Shared compare unit: keeps the heaviest weight seen in a scan and its node pair.
// Depends on ghe_pkg for the command and result structs.
`default_nettype none
module ghe_cmp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ghe_pkg::cmp_cmd_t            cmd,
  input  wire logic [ghe_pkg::WEIGHT_W-1:0] rdata,
  output ghe_pkg::cmp_res_t                 res
);
  logic [ghe_pkg::WEIGHT_W-1:0] best_r;
  logic                         found_r;
  logic [ghe_pkg::NODE_W-1:0]   ba_r;
  logic [ghe_pkg::NODE_W-1:0]   bb_r;

  // strict greater keeps the first (lowest index) of equal weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (cmd.clr) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (cmd.vld && (rdata > best_r)) begin
      found_r <= 1'b1;
      best_r  <= rdata;
      ba_r    <= cmd.a;
      bb_r    <= cmd.b;
    end
  end

  assign res.found = found_r;
  assign res.ba    = ba_r;
  assign res.bb    = bb_r;
endmodule
`default_nettype wire

FILE: hw/rtl/greedy_heaviest_edge_chain_order.sv
// Greedy heaviest-edge chain ordering of up to 64 nodes over a loaded weight store.
// Input words (in_ch): mode 0 writes one edge weight to the store; mode 1 runs
// the ordering and emits one out_ch word per placed node, with last set on the
// final word. Fewer than two nodes gives a single word flagged empty_res. The
// block takes no input word while a run or clear pass is going on.
// Sequencing: each pair search scans count*count store entries, one read a cycle;
// each neighbor step scans count entries; every word then passes through an emit
// step. The tail in ascending order steps through each index up to the last
// unplaced one and emits a word for each unplaced index. The single read port of
// the weight store bounds the scans.
// At reset and after every run a clearing pass writes zero to all MAX_NODES*MAX_NODES
// store words, one a cycle; input is held off meanwhile, configuration writes are
// taken at any time.
// Results sit in an output register; a stalled receiver holds the sequencer at
// its next result, and the last word may still wait while the clear pass runs.
// Depends on ghe_pkg, ghe_if, ghe_wmem, ghe_cmp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module greedy_heaviest_edge_chain_order #(
  parameter int MAX_NODES = ghe_pkg::DEF_MAX_NODES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ghe_in_if.sink                              in_ch,
  ghe_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ghe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ghe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int EFF_MAX = (MAX_NODES < ghe_pkg::NODE_LIMIT) ? MAX_NODES : ghe_pkg::NODE_LIMIT;
  localparam int DEPTH   = MAX_NODES * MAX_NODES;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = ghe_pkg::NODE_W;
  localparam int MW      = ghe_pkg::MASK_W;

  ghe_pkg::state_t st_r, ret_r;

  logic [ghe_pkg::COUNT_W-1:0] node_count_r;
  logic                        excl_en_r;
  logic [NW-1:0]               excl_node_r;

  logic [AW-1:0] clr_cnt_r;
  logic [MW-1:0] mask_r;
  logic [NW-1:0] cur_r, a_r, b_r, idx_r;
  logic          cur_valid_r, pair_r;
  logic          tag_vld_r;
  logic [NW-1:0] tag_a_r, tag_b_r;
  logic [NW-1:0] pend_node_r;
  logic          pend_last_r, pend_empty_r;
  logic          out_valid_r, out_last_r, out_empty_r;
  logic [NW-1:0] out_node_r;

  logic [ghe_pkg::COUNT_W-1:0]  eff;
  logic [NW-1:0]                eff_m1;
  logic                         excl_hit;
  logic [MW-1:0]                mask_init, mask_dec, mask_asc;
  logic                         in_fire, load_ok, scan_iss, emit_load;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [ghe_pkg::WEIGHT_W-1:0] mem_wdata, mem_rdata;
  ghe_pkg::cmp_cmd_t            cmd;
  ghe_pkg::cmp_res_t            res;

  assign eff = (int'(node_count_r) > EFF_MAX) ? ghe_pkg::COUNT_W'(EFF_MAX) : node_count_r;
  assign eff_m1   = NW'(eff - 7'd1);
  assign excl_hit = excl_en_r && ({1'b0, excl_node_r} < eff);

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      mask_init[i] = (ghe_pkg::COUNT_W'(i) < eff) && !(excl_hit && (excl_node_r == NW'(i)));
    end
  end

  assign mask_dec = mask_r & ~(MW'(1) << cur_r);
  assign mask_asc = mask_r & ~(MW'(1) << idx_r);

  assign in_ch.ready = (st_r == ghe_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_ok     = in_fire && !in_ch.mode && (int'(in_ch.from_node) < MAX_NODES)
                       && (int'(in_ch.to_node) < MAX_NODES);
  assign scan_iss    = (st_r == ghe_pkg::ST_PAIR) || (st_r == ghe_pkg::ST_NBR);
  assign emit_load   = (st_r == ghe_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);

  // store write: clear pass or edge load
  assign mem_we    = (st_r == ghe_pkg::ST_CLR) || load_ok;
  assign mem_waddr = (st_r == ghe_pkg::ST_CLR) ? clr_cnt_r :
                     AW'(AW'(in_ch.from_node) * AW'(MAX_NODES) + AW'(in_ch.to_node));
  assign mem_wdata = (st_r == ghe_pkg::ST_CLR) ? '0 : in_ch.edge_weight;
  assign mem_raddr = AW'(AW'(a_r) * AW'(MAX_NODES) + AW'(b_r));

  ghe_wmem #(.MAX_NODES(MAX_NODES)) u_wmem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  assign cmd.clr = (st_r == ghe_pkg::ST_SEL);
  assign cmd.vld = tag_vld_r;
  assign cmd.a   = tag_a_r;
  assign cmd.b   = tag_b_r;

  ghe_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rdata (mem_rdata),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      excl_en_r    <= 1'b0;
      excl_node_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ghe_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        ghe_pkg::CFG_EXCL_EN:    excl_en_r    <= cfg_wdata[0];
        ghe_pkg::CFG_EXCL_NODE:  excl_node_r  <= cfg_wdata[NW-1:0];
        default: ;
      endcase
    end
  end

  // tag travels with the read so the compare sees the pair of the returned word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= scan_iss && mask_r[a_r] && mask_r[b_r] && (a_r != b_r);
    end
    tag_a_r <= a_r;
    tag_b_r <= b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ghe_pkg::ST_CLR;
      ret_r       <= ghe_pkg::ST_CLR;
      clr_cnt_r   <= '0;
      mask_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      pair_r      <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      idx_r       <= '0;
    end else begin
      case (st_r)
        ghe_pkg::ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(DEPTH - 1)) begin
            clr_cnt_r   <= '0;
            mask_r      <= '0;
            cur_r       <= '0;
            cur_valid_r <= 1'b0;
            st_r        <= ghe_pkg::ST_IDLE;
          end
        end
        ghe_pkg::ST_IDLE: begin
          if (in_fire && in_ch.mode) begin
            mask_r      <= mask_init;
            cur_r       <= '0;
            cur_valid_r <= 1'b0;
            if (eff < ghe_pkg::COUNT_W'(ghe_pkg::MIN_NODES)) begin
              pend_node_r  <= '0;
              pend_last_r  <= 1'b1;
              pend_empty_r <= 1'b1;
              ret_r        <= ghe_pkg::ST_CLR;
              st_r         <= ghe_pkg::ST_EMIT;
            end else begin
              st_r <= ghe_pkg::ST_SEL;
            end
          end
        end
        ghe_pkg::ST_SEL: begin
          a_r    <= cur_valid_r ? cur_r : '0;
          b_r    <= '0;
          pair_r <= !cur_valid_r;
          st_r   <= cur_valid_r ? ghe_pkg::ST_NBR : ghe_pkg::ST_PAIR;
        end
        ghe_pkg::ST_PAIR: begin
          if (b_r == eff_m1) begin
            b_r <= '0;
            if (a_r == eff_m1) begin
              st_r <= ghe_pkg::ST_WAIT;
            end else begin
              a_r <= a_r + NW'(1);
            end
          end else begin
            b_r <= b_r + NW'(1);
          end
        end
        ghe_pkg::ST_NBR: begin
          if (b_r == eff_m1) begin
            st_r <= ghe_pkg::ST_WAIT;
          end else begin
            b_r <= b_r + NW'(1);
          end
        end
        ghe_pkg::ST_WAIT: begin
          st_r <= ghe_pkg::ST_DEC;
        end
        ghe_pkg::ST_DEC: begin
          pend_empty_r <= 1'b0;
          if (pair_r) begin
            if (!res.found) begin
              // no edge left: rest goes out in index order
              idx_r <= '0;
              st_r  <= ghe_pkg::ST_ASC;
            end else begin
              pend_node_r <= res.ba;
              pend_last_r <= 1'b0;
              mask_r      <= mask_r & ~(MW'(1) << res.ba);
              cur_r       <= res.bb;
              cur_valid_r <= 1'b1;
              ret_r       <= ghe_pkg::ST_SEL;
              st_r        <= ghe_pkg::ST_EMIT;
            end
          end else begin
            pend_node_r <= cur_r;
            pend_last_r <= (mask_dec == '0);
            mask_r      <= mask_dec;
            cur_valid_r <= res.found;
            cur_r       <= res.found ? res.bb : '0;
            ret_r       <= (mask_dec == '0) ? ghe_pkg::ST_CLR : ghe_pkg::ST_SEL;
            st_r        <= ghe_pkg::ST_EMIT;
          end
        end
        ghe_pkg::ST_ASC: begin
          idx_r <= idx_r + NW'(1);
          if (mask_r[idx_r]) begin
            pend_node_r  <= idx_r;
            pend_last_r  <= (mask_asc == '0);
            pend_empty_r <= 1'b0;
            mask_r       <= mask_asc;
            ret_r        <= (mask_asc == '0) ? ghe_pkg::ST_CLR : ghe_pkg::ST_ASC;
            st_r         <= ghe_pkg::ST_EMIT;
          end
        end
        ghe_pkg::ST_EMIT: begin
          if (emit_load) begin
            st_r <= ret_r;
          end
        end
        default: st_r <= ghe_pkg::ST_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_load) begin
      out_node_r  <= pend_node_r;
      out_last_r  <= pend_last_r;
      out_empty_r <= pend_empty_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.node      = out_node_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.empty_res = out_empty_r;

  `GHE_ASSERT(a_empty_is_last, clk, rst_n, (out_valid_r && out_empty_r) |-> out_last_r)
  `GHE_ASSERT(a_last_starts_clear, clk, rst_n, (emit_load && pend_last_r) |=> (st_r == ghe_pkg::ST_CLR))
  `GHE_ASSERT_NEVER(a_no_input_in_clear, clk, rst_n, (st_r == ghe_pkg::ST_CLR) && in_ch.ready)
  `GHE_ASSERT(a_tag_from_scan, clk, rst_n, tag_vld_r |-> ($past(st_r) == ghe_pkg::ST_PAIR || $past(st_r) == ghe_pkg::ST_NBR))
endmodule
`default_nettype wire
